FILE: rtl/core/gwwb_pkg.sv
`timescale 1ns / 1ps
package gwwb_pkg;
    localparam int MAX_PIXELS = 1048576;
    localparam int ADDR_W = $clog2(MAX_PIXELS);
    localparam int CNT_W = $clog2(MAX_PIXELS + 1);
    localparam int SUM_W = $clog2(MAX_PIXELS * 255 + 1);
    localparam int NUM_W = SUM_W + 8;
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_DIVIDE,
        ST_DRAIN
    } state_t;
endpackage

FILE: rtl/core/gwwb_divider.sv
`timescale 1ns / 1ps
module gwwb_divider
    import gwwb_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             go,
    input  logic [NUM_W-1:0] numer,
    input  logic [SUM_W-1:0] denom,
    output logic             done,
    output logic [7:0]       quot
);
    localparam int STEP_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0]  num_reg;
    logic [NUM_W-1:0]  q_reg;
    logic [SUM_W:0]    rem_reg;
    logic [SUM_W-1:0]  den_reg;
    logic [STEP_W-1:0] step_reg;
    logic              run_reg;
    logic [SUM_W:0]    shifted;
    logic              fits;

    // restoring division, one quotient bit a cycle
    assign shifted = {rem_reg[SUM_W-1:0], num_reg[NUM_W-1]};
    assign fits = shifted >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (go)
        begin
            run_reg <= 1'b1;
            step_reg <= STEP_W'(NUM_W);
        end
        else if (run_reg)
        begin
            step_reg <= step_reg - 1'b1;
            if (step_reg == STEP_W'(1))
                run_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            num_reg <= numer;
            den_reg <= denom;
            rem_reg <= '0;
            q_reg <= '0;
        end
        else if (run_reg)
        begin
            num_reg <= {num_reg[NUM_W-2:0], 1'b0};
            rem_reg <= fits ? (shifted - {1'b0, den_reg}) : shifted;
            q_reg <= {q_reg[NUM_W-2:0], fits};
        end
    end

    assign done = run_reg && step_reg == STEP_W'(1);
    // saturate to 255, quotient taken with the final bit
    logic [NUM_W-1:0] q_full;
    assign q_full = {q_reg[NUM_W-2:0], fits};
    assign quot = (q_full > NUM_W'(255)) ? 8'd255 : q_full[7:0];
endmodule

FILE: rtl/core/gray_world_white_balance_unit.sv
`timescale 1ns / 1ps
// loads and drains are accepted one beat per cycle while busy is low; a drain
// result strobes on done after the registered pixel read, then table read
// a frame_end load starts the table build: 256 values x 2 channels, each a setup
// state and then a serial division of NUM_W (36) bits, with busy high throughout
// reset clears counts, totals and the ready flag; memories are not cleared
// the receiver cannot stall: a result is on the ports for one cycle only
module gray_world_white_balance_unit
    import gwwb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic       cmd,
    input  logic [7:0] blue_in,
    input  logic [7:0] green_in,
    input  logic [7:0] red_in,
    input  logic       frame_end,
    output logic       done,
    output logic [7:0] blue_out,
    output logic [7:0] green_out,
    output logic [7:0] red_out,
    output logic       final_pixel
);
    logic [23:0] pixel_mem [MAX_PIXELS];
    // red entry in the upper byte, blue entry in the lower byte
    logic [15:0] table_mem [256];

    state_t state_reg, state_next;
    logic [SUM_W-1:0] bsum_reg, gsum_reg, rsum_reg;
    logic [CNT_W-1:0] count_reg, dpos_reg;
    logic ready_reg;
    logic gzero_reg;
    logic [7:0] v_reg;
    logic chan_reg;
    logic [7:0] bq_reg;
    logic rd_valid_reg, rd_final_reg;
    logic [23:0] pix_rd_reg;

    logic accept, load, drain_ok, last_drain, full, clr;
    logic div_go, div_done;
    logic [7:0] div_q;
    logic [NUM_W-1:0] numer;
    logic [SUM_W-1:0] denom;
    logic [7:0] b_ent, r_ent;

    assign accept = start && !busy;
    assign load = accept && cmd == CMD_LOAD;
    assign full = count_reg == CNT_W'(MAX_PIXELS);
    assign clr = load && ready_reg;
    assign drain_ok = accept && cmd == CMD_DRAIN && ready_reg && dpos_reg < count_reg;
    assign last_drain = drain_ok && (dpos_reg + 1'b1 == count_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (load && frame_end) state_next = ST_SETUP;
            ST_SETUP:  state_next = ST_DIVIDE;
            ST_DIVIDE: if (div_done && chan_reg && v_reg == 8'd255) state_next = ST_IDLE;
                       else if (div_done) state_next = ST_SETUP;
            default:   state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        busy = state_reg != ST_IDLE;
        div_go = state_reg == ST_SETUP;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            bsum_reg <= '0;
            gsum_reg <= '0;
            rsum_reg <= '0;
            count_reg <= '0;
            dpos_reg <= '0;
            ready_reg <= 1'b0;
            gzero_reg <= 1'b0;
            v_reg <= '0;
            chan_reg <= 1'b0;
            rd_valid_reg <= 1'b0;
            rd_final_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rd_valid_reg <= drain_ok;
            rd_final_reg <= last_drain;
            if (load)
            begin
                if (clr || !full)
                begin
                    bsum_reg <= (clr ? '0 : bsum_reg) + SUM_W'(blue_in);
                    gsum_reg <= (clr ? '0 : gsum_reg) + SUM_W'(green_in);
                    rsum_reg <= (clr ? '0 : rsum_reg) + SUM_W'(red_in);
                    count_reg <= (clr ? '0 : count_reg) + 1'b1;
                end
                dpos_reg <= '0;
                ready_reg <= frame_end;
                v_reg <= '0;
                chan_reg <= 1'b0;
            end
            else if (drain_ok)
            begin
                if (last_drain)
                begin
                    bsum_reg <= '0;
                    gsum_reg <= '0;
                    rsum_reg <= '0;
                    count_reg <= '0;
                    dpos_reg <= '0;
                    ready_reg <= 1'b0;
                end
                else
                    dpos_reg <= dpos_reg + 1'b1;
            end
            // green table is identity unless the green total is zero
            if (div_go)
                gzero_reg <= gsum_reg == '0;
            if (div_done)
            begin
                chan_reg <= !chan_reg;
                if (chan_reg)
                    v_reg <= v_reg + 1'b1;
            end
        end
    end

    // pixel store: write on load while there is room, read on drain
    always_ff @(posedge clk)
    begin
        if (load && (clr || !full))
            pixel_mem[clr ? '0 : count_reg[ADDR_W-1:0]] <= {red_in, green_in, blue_in};
        pix_rd_reg <= pixel_mem[dpos_reg[ADDR_W-1:0]];
    end

    // table build, blue then red per value
    assign numer = NUM_W'(gsum_reg) * NUM_W'(v_reg);
    assign denom = chan_reg ? rsum_reg : bsum_reg;

    gwwb_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (div_go),
        .numer (numer),
        .denom (denom),
        .done  (div_done),
        .quot  (div_q)
    );

    // zero totals override the quotient
    logic [7:0] entry;
    always_comb
    begin
        if (gsum_reg == '0)
            entry = 8'd0;
        else if (denom == '0)
            entry = (v_reg == 8'd0) ? 8'd0 : 8'd255;
        else
            entry = div_q;
    end

    always_ff @(posedge clk)
    begin
        if (div_done && !chan_reg)
            bq_reg <= entry;
        if (div_done && chan_reg)
            table_mem[v_reg] <= {entry, bq_reg};
    end

    // blue and red table reads, green from the pixel (zero for a zero green total), registered
    logic [15:0] tb_reg, tr_reg;
    logic [7:0] tg_reg;
    always_ff @(posedge clk)
    begin
        tb_reg <= table_mem[pix_rd_reg[7:0]];
        tr_reg <= table_mem[pix_rd_reg[23:16]];
        tg_reg <= gzero_reg ? 8'd0 : pix_rd_reg[15:8];
    end

    logic v2_reg, f2_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
            f2_reg <= 1'b0;
        end
        else
        begin
            v2_reg <= rd_valid_reg;
            f2_reg <= rd_final_reg;
        end
    end

    assign b_ent = tb_reg[7:0];
    assign r_ent = tr_reg[15:8];
    assign done = v2_reg;
    assign blue_out = b_ent;
    assign green_out = tg_reg;
    assign red_out = r_ent;
    assign final_pixel = f2_reg;

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !accept) else $error("accept while busy");
    a_final_valid: assert property (@(posedge clk) disable iff (!rst_n)
        final_pixel |-> done) else $error("final without result");
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        drain_ok |=> ##1 done) else $error("result lost");
endmodule

FILE: test/gwwb_checker.sv
`timescale 1ns / 1ps
module gwwb_checker
    import gwwb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic       busy,
    input  logic       cmd,
    input  logic [7:0] blue_in,
    input  logic [7:0] green_in,
    input  logic [7:0] red_in,
    input  logic       frame_end,
    input  logic       done,
    input  logic [7:0] blue_out,
    input  logic [7:0] green_out,
    input  logic [7:0] red_out,
    input  logic       final_pixel,
    output int         fail_count,
    output int         pending
);
    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic       last;
    } px_out_t;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } px_t;

    px_t               frame_pixels[$];
    px_out_t           corrected_q[$];
    longint unsigned   sum_b;
    longint unsigned   sum_g;
    longint unsigned   sum_r;
    int                drain_idx;
    bit                ready;
    logic [7:0]        lut_b[256];
    logic [7:0]        lut_g[256];
    logic [7:0]        lut_r[256];

    assign pending = corrected_q.size();

    // one table entry: the value scaled by green average over channel average, clipped
    function automatic logic [7:0] gain_of(longint unsigned g_sum, longint unsigned c_sum,
                                           int v);
        longint unsigned q;
        if (g_sum == 0)
            return 8'd0;
        if (c_sum == 0)
            return (v == 0) ? 8'd0 : 8'd255;
        q = (g_sum * longint'(v)) / c_sum;
        return (q > 255) ? 8'd255 : q[7:0];
    endfunction

    function automatic void new_frame();
        frame_pixels.delete();
        sum_b = 0;
        sum_g = 0;
        sum_r = 0;
        drain_idx = 0;
        ready = 0;
    endfunction

    initial
    begin
        new_frame();
    end

    // predict on each accepted beat
    always @(posedge clk)
    begin
        px_t     p;
        px_out_t e;
        px_t     s;
        if (rst_n && start && !busy)
        begin
            if (cmd == CMD_LOAD)
            begin
                if (ready)
                    new_frame();
                if (frame_pixels.size() < MAX_PIXELS)
                begin
                    p.blue = blue_in;
                    p.green = green_in;
                    p.red = red_in;
                    frame_pixels.insert(frame_pixels.size(), p);
                    sum_b += blue_in;
                    sum_g += green_in;
                    sum_r += red_in;
                end
                if (frame_end)
                begin
                    for (int v = 0; v < 256; v++)
                    begin
                        lut_b[v] = gain_of(sum_g, sum_b, v);
                        lut_g[v] = gain_of(sum_g, sum_g, v);
                        lut_r[v] = gain_of(sum_g, sum_r, v);
                    end
                    drain_idx = 0;
                    ready = 1;
                end
            end
            else if (ready && drain_idx < frame_pixels.size())
            begin
                s = frame_pixels[drain_idx];
                e.blue = lut_b[s.blue];
                e.green = lut_g[s.green];
                e.red = lut_r[s.red];
                e.last = (drain_idx + 1 == frame_pixels.size());
                corrected_q.insert(corrected_q.size(), e);
                drain_idx++;
                if (e.last)
                    new_frame();
            end
        end
    end

    // compare each strobed result with the oldest prediction
    always @(posedge clk)
    begin
        px_out_t e;
        if (rst_n && done)
        begin
            if (corrected_q.size() == 0)
            begin
                $display("%0t: unexpected result b=%0d g=%0d r=%0d f=%0d", $time,
                         blue_out, green_out, red_out, final_pixel);
                fail_count++;
            end
            else
            begin
                e = corrected_q.pop_front();
                if (blue_out !== e.blue)
                begin
                    $display("%0t: blue expected %0d actual %0d", $time, e.blue, blue_out);
                    fail_count++;
                end
                if (green_out !== e.green)
                begin
                    $display("%0t: green expected %0d actual %0d", $time, e.green, green_out);
                    fail_count++;
                end
                if (red_out !== e.red)
                begin
                    $display("%0t: red expected %0d actual %0d", $time, e.red, red_out);
                    fail_count++;
                end
                if (final_pixel !== e.last)
                begin
                    $display("%0t: final_pixel expected %0d actual %0d", $time, e.last,
                             final_pixel);
                    fail_count++;
                end
            end
        end
    end
endmodule

FILE: test/tb_gray_world_white_balance_unit.sv
`timescale 1ns / 1ps
module tb_gray_world_white_balance_unit
    import gwwb_pkg::*;
();

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    logic       cmd;
    logic [7:0] blue_in;
    logic [7:0] green_in;
    logic [7:0] red_in;
    logic       frame_end;
    logic       done;
    logic [7:0] blue_out;
    logic [7:0] green_out;
    logic [7:0] red_out;
    logic       final_pixel;
    int         fail_count;
    int         pending;
    int         idle_pct;
    int         beats;

    gray_world_white_balance_unit dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd),
        .blue_in(blue_in), .green_in(green_in), .red_in(red_in), .frame_end(frame_end),
        .done(done), .blue_out(blue_out), .green_out(green_out), .red_out(red_out),
        .final_pixel(final_pixel)
    );

    gwwb_checker u_checker (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd),
        .blue_in(blue_in), .green_in(green_in), .red_in(red_in), .frame_end(frame_end),
        .done(done), .blue_out(blue_out), .green_out(green_out), .red_out(red_out),
        .final_pixel(final_pixel), .fail_count(fail_count), .pending(pending)
    );

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    // one beat, with an optional idle gap in front
    task automatic send(logic c, logic [7:0] b, logic [7:0] g, logic [7:0] r, logic fe);
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        start <= 1;
        cmd <= c;
        blue_in <= b;
        green_in <= g;
        red_in <= r;
        frame_end <= fe;
        do @(posedge clk); while (busy);
        beats++;
    endtask

    task automatic drain(int n);
        repeat (n) send(CMD_DRAIN, 8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
    endtask

    // random frame: channel masks skew the averages so clipping shows up
    task automatic random_frame(int n);
        logic [7:0] mb, mg, mr;
        mb = ($urandom_range(3) == 0) ? 8'h0f : 8'hff;
        mg = ($urandom_range(5) == 0) ? 8'h00 : 8'hff;
        mr = ($urandom_range(3) == 0) ? 8'h3f : 8'hff;
        for (int i = 0; i < n; i++)
            send(CMD_LOAD, 8'($urandom) & mb, 8'($urandom) & mg, 8'($urandom) & mr,
                 i == n - 1);
    endtask

    initial
    begin
        int n;
        start = 0;
        cmd = CMD_LOAD;
        blue_in = 0;
        green_in = 0;
        red_in = 0;
        frame_end = 0;
        beats = 0;
        idle_pct = 28;
        rst_n = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // drain with nothing loaded
        drain(2);
        // extremes with clipping
        send(CMD_LOAD, 8'd0, 8'd255, 8'd255, 0);
        send(CMD_LOAD, 8'd1, 8'd255, 8'd0, 0);
        send(CMD_LOAD, 8'd255, 8'd0, 8'd128, 1);
        drain(4);
        // zero blue total
        send(CMD_LOAD, 8'd0, 8'd10, 8'd200, 0);
        send(CMD_LOAD, 8'd0, 8'd90, 8'd3, 1);
        drain(2);
        // zero green total
        send(CMD_LOAD, 8'd77, 8'd0, 8'd255, 1);
        drain(1);
        // abandon a partly drained frame, then a one-pixel frame
        send(CMD_LOAD, 8'd20, 8'd40, 8'd80, 0);
        send(CMD_LOAD, 8'd200, 8'd100, 8'd50, 1);
        drain(1);
        send(CMD_LOAD, 8'd255, 8'd255, 8'd255, 1);
        drain(2);

        // random frames across the three idle phases
        while (beats < 1300)
        begin
            idle_pct = (beats < 430) ? 28 : (beats < 860) ? 63 : 0;
            n = $urandom_range(1, 40);
            if ($urandom_range(9) == 0)
                drain($urandom_range(1, 2));
            random_frame(n);
            case ($urandom_range(9))
                0: drain($urandom_range(0, n - 1));
                1: drain(n + $urandom_range(1, 3));
                default: drain(n);
            endcase
        end
        start <= 0;

        wait (pending == 0);
        @(posedge clk);
        while (busy) @(posedge clk);
        repeat (5) @(posedge clk);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // each frame waits for a full table build, so the timeout is long
    initial
    begin
        #2000ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

FILE: files.f
rtl/core/gwwb_pkg.sv
rtl/core/gwwb_divider.sv
rtl/core/gray_world_white_balance_unit.sv
test/gwwb_checker.sv
test/tb_gray_world_white_balance_unit.sv
